// File: src/polygon_interior_seed_search_macros.svh
// Assertion macros for the polygon interior seed search block.
`ifndef POLYGON_INTERIOR_SEED_SEARCH_MACROS_SVH
`define POLYGON_INTERIOR_SEED_SEARCH_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked in the same cycle.
`define PIS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pis assertion failed");
// Implication checked in the next cycle.
`define PIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pis assertion failed");
`else
`define PIS_ASSERT_NOW(label, ante, cons)
`define PIS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: src/pis_pkg.sv
// Shared constants for the polygon interior seed search block.
`default_nettype none
package pis_pkg;
  localparam int COORD_W         = 32;
  localparam int MAX_CORNERS_DEF = 256;
  localparam int MIN_SUBSET      = 3;
endpackage
`default_nettype wire

// File: src/pis_vertex_if.sv
// Vertex input channel: valid, ready and one polygon vertex.
`default_nettype none
interface pis_vertex_if import pis_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] vertex_x;
  logic signed [COORD_W-1:0] vertex_y;
  logic                      last_vertex;
  modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface
`default_nettype wire

// File: src/pis_result_if.sv
// Result output channel: valid, ready and the seed search outcome.
`default_nettype none
interface pis_result_if import pis_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic signed [COORD_W-1:0] seed_x;
  logic signed [COORD_W-1:0] seed_y;
  logic                      too_many_vertices;
  modport source (output valid, found, seed_x, seed_y, too_many_vertices, input ready);
  modport sink (input valid, found, seed_x, seed_y, too_many_vertices, output ready);
endinterface
`default_nettype wire

// File: src/polygon_interior_seed_search.sv
// Top level: vertex store, centroid trials and ray-crossing parity test.
//
//  channel | dir | payload                                      | accepted when
//  vin     | in  | vertex_x, vertex_y, last_vertex               | valid && ready
//  res     | out | found, seed_x, seed_y, too_many_vertices      | valid && ready
//
// Vertices load at one per cycle into a vertex memory (x and y in one word) with one write and
// one read port. On the last vertex the search runs with vin stalled: per subset size the sums
// are read and accumulated, then per trial the two dividers run, the edges are tested in turn
// and the sliding sums are updated; the one read port sets the pace.
// Reset is synchronous; it clears the count and overflow flag, no memory clearing pass.
// A waiting result does not stall loading of the next polygon.
`default_nettype none
module polygon_interior_seed_search
  import pis_pkg::*;
#(
  parameter int MAX_CORNERS = MAX_CORNERS_DEF
) (
  input wire logic     clk,
  input wire logic     rst,
  pis_vertex_if.sink   vin,
  pis_result_if.source res
);
  localparam int AW = $clog2(MAX_CORNERS);
  localparam int CW = $clog2(MAX_CORNERS + 1);
  localparam int SW = COORD_W + CW;
  localparam int DW = COORD_W + 1;
  localparam int PW = 2 * DW;

  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_START    = 4'd1;
  localparam logic [3:0] S_SUM_RD   = 4'd2;
  localparam logic [3:0] S_SUM_ACC  = 4'd3;
  localparam logic [3:0] S_DIV      = 4'd4;
  localparam logic [3:0] S_DIV_WAIT = 4'd5;
  localparam logic [3:0] S_EDGE_RD  = 4'd6;
  localparam logic [3:0] S_EDGE_LD  = 4'd7;
  localparam logic [3:0] S_EDGE_MUL = 4'd8;
  localparam logic [3:0] S_EDGE_CMP = 4'd9;
  localparam logic [3:0] S_DECIDE   = 4'd10;
  localparam logic [3:0] S_UPD_OLD  = 4'd11;
  localparam logic [3:0] S_UPD_RDN  = 4'd12;
  localparam logic [3:0] S_UPD_NEU  = 4'd13;
  localparam logic [3:0] S_FIN      = 4'd14;

  logic [3:0] state;

  // Vertex memory, x in the upper half
  logic [2*COORD_W-1:0] mem [MAX_CORNERS];
  logic [2*COORD_W-1:0] rd_data;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          ovf;
  logic [CW-1:0] n;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic [CW-1:0] k;
  logic [CW:0]   neu_raw;
  logic [CW-1:0] neu;

  logic signed [SW-1:0]      sx;
  logic signed [SW-1:0]      sy;
  logic signed [COORD_W-1:0] tx;
  logic signed [COORD_W-1:0] ty;
  logic                      found;
  logic                      fin_go;

  logic                      div_start;
  logic                      dx_done;
  logic                      dy_done;
  logic signed [SW-1:0]      qx;
  logic signed [SW-1:0]      qy;

  logic signed [COORD_W-1:0] cur_x;
  logic signed [COORD_W-1:0] cur_y;
  logic signed [COORD_W-1:0] prev_x;
  logic signed [COORD_W-1:0] prev_y;

  logic signed [DW-1:0] d_dx;
  logic signed [DW-1:0] d_t;
  logic signed [DW-1:0] d_d;
  logic signed [DW-1:0] d_e;
  logic [DW-1:0]        m_dx;
  logic [DW-1:0]        m_t;
  logic [DW-1:0]        m_d;
  logic [DW-1:0]        m_e;
  logic                 n_dx;
  logic                 n_e;
  logic                 e_skip;
  logic                 e_deg;
  logic [PW-1:0]        lm;
  logic [PW-1:0]        rm;
  logic                 nl;
  logic                 nr;
  logic                 c_eq;
  logic                 c_gt;
  logic                 parity;
  logic                 degen;

  assign cur_x = rd_data[2*COORD_W-1:COORD_W];
  assign cur_y = rd_data[COORD_W-1:0];

  // Memory: one write port while loading, one registered read port
  assign wr_en = vin.valid && vin.ready && (count < CW'(MAX_CORNERS));
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[AW-1:0]] <= {vin.vertex_x, vin.vertex_y};
    end
    rd_data <= mem[rd_addr];
  end

  // Wrapped index of the vertex entering the sliding subset
  assign neu_raw = {1'b0, i} - (CW+1)'(1) + {1'b0, n};
  assign neu     = (neu_raw >= {1'b0, count}) ? CW'(neu_raw - {1'b0, count})
                                              : neu_raw[CW-1:0];

  // Read address per phase
  always_comb begin
    case (state)
      S_SUM_RD:  rd_addr = j[AW-1:0];
      S_EDGE_RD: rd_addr = k[AW-1:0];
      S_DECIDE:  rd_addr = i[AW-1:0];
      S_UPD_RDN: rd_addr = neu[AW-1:0];
      default:   rd_addr = '0;
    endcase
  end

  assign count_next = wr_en ? count + CW'(1) : count;
  assign vin.ready  = (state == S_LOAD);
  assign div_start  = (state == S_DIV);
  assign fin_go     = (state == S_FIN) && (!res.valid || res.ready);

  pis_div #(.SW(SW), .CW(CW)) u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .dividend(sx), .divisor(n),
    .done(dx_done), .quotient(qx)
  );
  pis_div #(.SW(SW), .CW(CW)) u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .dividend(sy), .divisor(n),
    .done(dy_done), .quotient(qy)
  );

  // Edge differences; vertex k is the edge start, vertex k-1 its end
  assign d_dx = DW'(prev_x) - DW'(cur_x);
  assign d_t  = DW'(ty) - DW'(cur_y);
  assign d_d  = DW'(prev_y) - DW'(cur_y);
  assign d_e  = DW'(tx) - DW'(cur_x);

  // Sign-magnitude compare of the two cross products
  assign nl   = n_dx && (lm != '0);
  assign nr   = n_e && (rm != '0);
  assign c_eq = (nl == nr) && (lm == rm);
  assign c_gt = (nl != nr) ? !nl : (nl ? (lm < rm) : (lm > rm));

  // Search sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (fin_go) begin
        res.valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (vin.valid) begin
            count <= count_next;
            if (!wr_en) begin
              ovf <= 1'b1;
            end
            if (vin.last_vertex) begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          found <= 1'b0;
          tx    <= '0;
          ty    <= '0;
          n     <= count - CW'(1);
          i     <= '0;
          j     <= '0;
          sx    <= '0;
          sy    <= '0;
          state <= (count < CW'(MIN_SUBSET + 1)) ? S_FIN : S_SUM_RD;
        end
        S_SUM_RD: begin
          state <= S_SUM_ACC;
        end
        S_SUM_ACC: begin
          sx <= sx + SW'(cur_x);
          sy <= sy + SW'(cur_y);
          j  <= j + CW'(1);
          state <= (j + CW'(1) == n) ? S_DIV : S_SUM_RD;
        end
        S_DIV: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (dx_done && dy_done) begin
            tx     <= qx[COORD_W-1:0];
            ty     <= qy[COORD_W-1:0];
            k      <= '0;
            parity <= 1'b0;
            degen  <= 1'b0;
            state  <= S_EDGE_RD;
          end
        end
        S_EDGE_RD: begin
          state <= S_EDGE_LD;
        end
        S_EDGE_LD: begin
          prev_x <= cur_x;
          prev_y <= cur_y;
          if (k == '0) begin
            k     <= CW'(1);
            state <= S_EDGE_RD;
          end else begin
            e_deg  <= (ty == cur_y) || (ty == prev_y);
            e_skip <= ((cur_y > ty) && (prev_y > ty)) || ((cur_y < ty) && (prev_y < ty));
            n_dx   <= d_dx[DW-1];
            n_e    <= d_e[DW-1];
            m_dx   <= d_dx[DW-1] ? DW'(-d_dx) : DW'(d_dx);
            m_t    <= d_t[DW-1] ? DW'(-d_t) : DW'(d_t);
            m_d    <= d_d[DW-1] ? DW'(-d_d) : DW'(d_d);
            m_e    <= d_e[DW-1] ? DW'(-d_e) : DW'(d_e);
            state  <= S_EDGE_MUL;
          end
        end
        S_EDGE_MUL: begin
          lm    <= m_dx * m_t;
          rm    <= m_e * m_d;
          state <= S_EDGE_CMP;
        end
        S_EDGE_CMP: begin
          if (e_deg || (!e_skip && c_eq)) begin
            degen <= 1'b1;
          end else if (!e_skip && c_gt) begin
            parity <= !parity;
          end
          k     <= k + CW'(1);
          state <= (k + CW'(1) == count) ? S_DECIDE : S_EDGE_RD;
        end
        S_DECIDE: begin
          // Read address here is the vertex leaving the subset
          if (parity && !degen) begin
            found <= 1'b1;
            state <= S_FIN;
          end else if (i + CW'(2) < count) begin
            i     <= i + CW'(1);
            state <= S_UPD_OLD;
          end else if (n > CW'(MIN_SUBSET)) begin
            n     <= n - CW'(1);
            i     <= '0;
            j     <= '0;
            sx    <= '0;
            sy    <= '0;
            state <= S_SUM_RD;
          end else begin
            tx    <= '0;
            ty    <= '0;
            state <= S_FIN;
          end
        end
        S_UPD_OLD: begin
          sx    <= sx - SW'(cur_x);
          sy    <= sy - SW'(cur_y);
          state <= S_UPD_RDN;
        end
        S_UPD_RDN: begin
          state <= S_UPD_NEU;
        end
        S_UPD_NEU: begin
          sx    <= sx + SW'(cur_x);
          sy    <= sy + SW'(cur_y);
          state <= S_DIV;
        end
        S_FIN: begin
          // Hold until the output register is free
          if (fin_go) begin
            res.found             <= found;
            res.seed_x            <= tx;
            res.seed_y            <= ty;
            res.too_many_vertices <= ovf;
            count                 <= '0;
            ovf                   <= 1'b0;
            state                 <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

`include "polygon_interior_seed_search_macros.svh"
  `PIS_ASSERT_NOW(a_count_cap, 1'b1, count <= CW'(MAX_CORNERS))
  `PIS_ASSERT_NOW(a_zero_seed, res.valid && !res.found, res.seed_x == '0 && res.seed_y == '0)
  `PIS_ASSERT_NOW(a_edge_index, state == S_EDGE_CMP, k != '0 && k < count)
  `PIS_ASSERT_NEXT(a_div_launch, state == S_DIV, state == S_DIV_WAIT)
endmodule
`default_nettype wire

// File: src/pis_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating.
`default_nettype none
module pis_div #(
  parameter int SW = 41,
  parameter int CW = 9
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [SW-1:0] dividend,
  input  wire logic [CW-1:0]        divisor,
  output logic                      done,
  output logic signed [SW-1:0]      quotient
);
  localparam int STW = $clog2(SW + 1);

  logic [SW-1:0]  q;
  logic [CW-1:0]  rem;
  logic [CW-1:0]  dvs;
  logic [STW-1:0] steps;
  logic           busy;
  logic           neg;
  logic [CW:0]    rem_sh;
  logic           fits;

  // Shift in the next dividend bit and trial subtract
  assign rem_sh = {rem, q[SW-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STW'(SW);
        neg   <= dividend[SW-1];
        q     <= dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
        rem   <= '0;
        dvs   <= divisor;
      end else if (busy) begin
        rem   <= fits ? CW'(rem_sh - {1'b0, dvs}) : rem_sh[CW-1:0];
        q     <= {q[SW-2:0], fits};
        steps <= steps - STW'(1);
        if (steps == STW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Apply the sign; truncation toward zero follows from the magnitude form
  assign quotient = neg ? -$signed(q) : $signed(q);
endmodule
`default_nettype wire

// File: bench/tb_polygon_interior_seed_search.sv
// Testbench for the polygon interior seed search block: directed and random polygons.
`default_nettype none
module tb_polygon_interior_seed_search;
  import pis_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CORNERS    = MAX_CORNERS_DEF;
  localparam int IDLE_LIMIT = 500000;
  localparam int HOLD_LEN   = 400;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    logic   found;
    coord_t seed_x;
    coord_t seed_y;
    logic   too_many;
  } seed_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pis_vertex_if vin ();
  pis_result_if res ();

  polygon_interior_seed_search u_dut (
    .clk (clk),
    .rst (rst),
    .vin (vin.sink),
    .res (res.source)
  );

  // Shadow polygon store
  coord_t shadow_x [CORNERS];
  coord_t shadow_y [CORNERS];
  int     shadow_count = 0;
  bit     shadow_overflow = 1'b0;

  seed_result_t pending_seeds[$];
  int errors = 0;
  int vertices_sent = 0;
  int polygons_sent = 0;
  int seeds_found = 0;
  int overflow_polygons = 0;
  int idle_pct = 10;
  bit hold_request = 1'b0;
  int idle_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  // Sign-magnitude compare: -1 less, 0 equal, +1 greater
  function automatic int compare_sm(bit n1, longint unsigned m1, bit n2, longint unsigned m2);
    if (m1 == 0) n1 = 1'b0;
    if (m2 == 0) n2 = 1'b0;
    if (n1 != n2) return n1 ? -1 : 1;
    if (m1 == m2) return 0;
    if (!n1) return (m1 > m2) ? 1 : -1;
    return (m1 > m2) ? -1 : 1;
  endfunction

  // Edge test: +1 crossing right of point, 0 none, -1 degenerate
  function automatic int edge_crossing(longint px, longint py, longint x1, longint y1,
                                       longint x2, longint y2);
    longint dx, t, d;
    longint unsigned lm, rm;
    int c;
    if (py == y1 || py == y2) return -1;
    if (y1 > py && y2 > py) return 0;
    if (y1 < py && y2 < py) return 0;
    if (y1 == y2) return -1;
    dx = x2 - x1;
    t  = py - y1;
    d  = y2 - y1;
    lm = magnitude(dx) * magnitude(t);
    rm = magnitude(px - x1) * magnitude(d);
    c  = compare_sm(dx < 0, lm, (px - x1) < 0, rm);
    if (c == 0) return -1;
    return (c > 0) ? 1 : 0;
  endfunction

  function automatic bit trial_inside(longint px, longint py, int nv);
    int crossings;
    int r;
    crossings = 0;
    for (int k = 0; k + 1 < nv; k++) begin
      r = edge_crossing(px, py, shadow_x[k+1], shadow_y[k+1], shadow_x[k], shadow_y[k]);
      if (r < 0) return 1'b0;
      crossings += r;
    end
    return crossings[0];
  endfunction

  // Walk subset sizes and start positions until a centroid lands inside
  function automatic seed_result_t search_seed();
    seed_result_t r;
    int nv, old_i, new_i;
    longint sx, sy, tx, ty;
    bit hit;
    nv = shadow_count;
    hit = 1'b0;
    tx = 0;
    ty = 0;
    for (int n = (nv >= 1) ? nv - 1 : 0; n >= MIN_SUBSET && !hit; n--) begin
      sx = 0;
      sy = 0;
      for (int j = 0; j < n; j++) begin
        sx += shadow_x[j % nv];
        sy += shadow_y[j % nv];
      end
      for (int i = 0; i + 1 < nv && !hit; i++) begin
        if (i > 0) begin
          old_i = i - 1;
          new_i = (i - 1 + n) % nv;
          sx += longint'(shadow_x[new_i]) - longint'(shadow_x[old_i]);
          sy += longint'(shadow_y[new_i]) - longint'(shadow_y[old_i]);
        end
        tx = sx / n;
        ty = sy / n;
        hit = trial_inside(tx, ty, nv);
      end
    end
    r.found    = hit;
    r.seed_x   = hit ? coord_t'(tx[31:0]) : '0;
    r.seed_y   = hit ? coord_t'(ty[31:0]) : '0;
    r.too_many = shadow_overflow;
    return r;
  endfunction

  // Send one vertex item; update the shadow store on acceptance
  task automatic send_vertex(coord_t x, coord_t y, bit last);
    seed_result_t r;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      vin.valid = 1'b0;
      @(negedge clk);
    end
    vin.valid       = 1'b1;
    vin.vertex_x    = x;
    vin.vertex_y    = y;
    vin.last_vertex = last;
    @(posedge clk);
    while (!vin.ready) @(posedge clk);
    vertices_sent++;
    if (shadow_count < CORNERS) begin
      shadow_x[shadow_count] = x;
      shadow_y[shadow_count] = y;
      shadow_count++;
    end else begin
      shadow_overflow = 1'b1;
    end
    if (last) begin
      r = search_seed();
      pending_seeds.push_back(r);
      polygons_sent++;
      if (r.found) seeds_found++;
      if (r.too_many) overflow_polygons++;
      shadow_count = 0;
      shadow_overflow = 1'b0;
    end
    @(negedge clk);
  endtask

  // Send a list of corners, then close with a repeat of the first
  task automatic send_polygon(coord_t xs[$], coord_t ys[$]);
    foreach (xs[k]) send_vertex(xs[k], ys[k], 1'b0);
    send_vertex(xs[0], ys[0], 1'b1);
  endtask

  // Drain results, then let the block settle
  task automatic wait_drained();
    vin.valid = 1'b0;
    while (pending_seeds.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Result sink: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      res.ready = 1'b0;
    end else if (hold_request) begin
      res.ready = 1'b0;
      repeat (HOLD_LEN) @(negedge clk);
      hold_request = 1'b0;
      res.ready = 1'b1;
    end else begin
      res.ready = (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    seed_result_t e;
    if (!rst && res.valid && res.ready) begin
      if (pending_seeds.size() == 0) begin
        $display("%0t: unexpected result found=%b x=%0d y=%0d", $time,
                 res.found, res.seed_x, res.seed_y);
        errors++;
      end else begin
        e = pending_seeds.pop_front();
        if (res.found !== e.found) begin
          $display("%0t: found expected %b actual %b", $time, e.found, res.found);
          errors++;
        end
        if (res.seed_x !== e.seed_x) begin
          $display("%0t: seed_x expected %0d actual %0d", $time, e.seed_x, res.seed_x);
          errors++;
        end
        if (res.seed_y !== e.seed_y) begin
          $display("%0t: seed_y expected %0d actual %0d", $time, e.seed_y, res.seed_y);
          errors++;
        end
        if (res.too_many_vertices !== e.too_many) begin
          $display("%0t: too_many_vertices expected %b actual %b", $time,
                   e.too_many, res.too_many_vertices);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((vin.valid && vin.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic coord_t small_coord();
    return coord_t'(int'($urandom_range(0, 8000)) - 4000);
  endfunction

  // Squares, a triangle, short polygons, extremes, a degenerate line
  task automatic test_directed();
    coord_t xs[$], ys[$];
    xs = '{0, 2560, 2560, 0};
    ys = '{0, 0, 2560, 2560};
    send_polygon(xs, ys);
    xs = '{0, 3000, 700};
    ys = '{0, 100, 2900};
    send_polygon(xs, ys);
    send_vertex(5, 5, 1'b1);
    send_vertex(5, 5, 1'b0);
    send_vertex(9, 9, 1'b1);
    xs = '{-100, 100};
    ys = '{-100, 50};
    send_polygon(xs, ys);
    xs = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_fff0, 32'sh8000_0010};
    ys = '{32'sh8000_0000, 32'sh8000_0010, 32'sh7fff_ffff, 32'sh7fff_fff0};
    send_polygon(xs, ys);
    xs = '{0, 256, 512, 768};
    ys = '{0, 256, 512, 768};
    send_polygon(xs, ys);
    wait_drained();
  endtask

  // Fill past capacity; stored corners form a closed convex polygon
  task automatic test_overflow();
    for (int k = 0; k < 128; k++)
      send_vertex(coord_t'(k * (255 - k) * 4), coord_t'(k * 1024 + 3), 1'b0);
    for (int k = 127; k > 0; k--)
      send_vertex(coord_t'(-k * (255 - k) * 4 - 7), coord_t'(k * 1024 + 517), 1'b0);
    send_vertex(0, 3, 1'b0);
    repeat (5) send_vertex(small_coord(), small_coord(), 1'b0);
    send_vertex(0, 3, 1'b1);
    wait_drained();
  endtask

  // Hold the sink off while polygons keep coming, so the input stalls
  task automatic test_backpressure();
    coord_t xs[$], ys[$];
    hold_request = 1'b1;
    xs = '{0, 4000, 4100, 100};
    ys = '{0, 50, 3900, 4000};
    repeat (6) send_polygon(xs, ys);
    wait_drained();
  endtask

  // Random polygons: mostly closed with random corners, some left open
  task automatic test_random(int target);
    int nv;
    bit wide, closed;
    coord_t fx, fy, x, y;
    while (vertices_sent < target) begin
      if (vertices_sent > target / 2 && vertices_sent < target / 2 + 150) idle_pct = 0;
      else idle_pct = 10;
      nv = $urandom_range(2, 8);
      wide = ($urandom_range(9) == 0);
      closed = ($urandom_range(9) < 8);
      for (int k = 0; k < nv; k++) begin
        x = wide ? coord_t'($urandom) : small_coord();
        y = wide ? coord_t'($urandom) : small_coord();
        if (k == 0) begin
          fx = x;
          fy = y;
        end
        send_vertex(x, y, 1'b0);
      end
      if (closed) send_vertex(fx, fy, 1'b1);
      else send_vertex(small_coord(), small_coord(), 1'b1);
    end
    idle_pct = 10;
    wait_drained();
  endtask

  initial begin
    vin.valid       = 1'b0;
    vin.vertex_x    = '0;
    vin.vertex_y    = '0;
    vin.last_vertex = 1'b0;
    res.ready       = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_overflow();
    test_backpressure();
    test_random(900);
    repeat (200) @(posedge clk);
    $display("Covered %0d vertices in %0d polygons: %0d seeds found, %0d over capacity.",
             vertices_sent, polygons_sent, seeds_found, overflow_polygons);
    if (errors == 0 && pending_seeds.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
